// ----- design/arpc_pkg.sv -----
package arpc_pkg;

  localparam int CACHE_DEPTH_DEF = 64;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP = 1'd0;

  localparam logic [1:0] OP_RX_REQ   = 2'd0;
  localparam logic [1:0] OP_RX_REPLY = 2'd1;
  localparam logic [1:0] OP_RESOLVE  = 2'd2;
  localparam logic [1:0] OP_CLOSE    = 2'd3;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_BCAST  = 3'd1;
  localparam logic [2:0] KIND_REPLY  = 3'd2;
  localparam logic [2:0] KIND_ANSWER = 3'd3;
  localparam logic [2:0] KIND_FULL   = 3'd4;

  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic [7:0]  iface;
    logic [15:0] hw_type;
    logic [7:0]  hw_len;
    logic [7:0]  client;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] dest_mac;
    logic [31:0] dest_ip;
    logic [7:0]  answer_client;
    logic [47:0] answer_mac;
    logic [7:0]  out_iface;
    logic [15:0] out_hw_type;
    logic [7:0]  out_hw_len;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [7:0]  iface;
    logic [15:0] hw_type;
    logic [7:0]  waiter;
  } entry_t;

endpackage

// ----- design/arpc_table.sv -----
module arpc_table #(
  parameter int CACHE_DEPTH = arpc_pkg::CACHE_DEPTH_DEF,
  localparam int AW = $clog2(CACHE_DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  arpc_pkg::entry_t    wr_entry,
  input  logic [AW-1:0]       rd_addr,
  input  logic [31:0]         key,
  output arpc_pkg::entry_t    rd_entry,
  output logic                rd_match
);

  arpc_pkg::entry_t mem [CACHE_DEPTH];
  arpc_pkg::entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry_r <= mem[rd_addr];
  end

  // shared compare unit: one stored entry against the lookup key per cycle
  assign rd_entry = rd_entry_r;
  assign rd_match = rd_entry_r.valid && (rd_entry_r.ip == key);

endmodule

// ----- design/arpc_ctrl.sv -----
module arpc_ctrl #(
  parameter int CACHE_DEPTH = arpc_pkg::CACHE_DEPTH_DEF,
  localparam int AW = $clog2(CACHE_DEPTH),
  localparam int CW = $clog2(CACHE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  arpc_pkg::in_item_t  in_item,
  output logic                busy,
  input  logic [31:0]         local_ip,
  output logic [31:0]         key,
  output logic [AW-1:0]       rd_addr,
  input  logic                rd_match,
  input  arpc_pkg::entry_t    rd_entry,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output arpc_pkg::entry_t    wr_entry,
  output logic                out_valid,
  output arpc_pkg::out_item_t out_item
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_ACT  = 3'b100
  } state_t;

  localparam logic [CW-1:0] DEPTH_C = CW'(CACHE_DEPTH);

  state_t              state_r, state_nxt;
  arpc_pkg::in_item_t  item_r, item_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic                cmp_v_r, cmp_v_nxt;
  logic [AW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                hit_r, hit_nxt;
  logic [AW-1:0]       row_r, row_nxt;
  arpc_pkg::entry_t    hit_ent_r, hit_ent_nxt;
  logic                out_valid_r, out_valid_nxt;
  arpc_pkg::out_item_t out_item_r, out_item_nxt;

  logic          issue;
  logic          full;
  logic [AW-1:0] new_slot;

  assign busy      = (state_r != S_IDLE);
  assign rd_addr   = idx_r[AW-1:0];
  assign issue     = (idx_r < fill_r);
  assign full      = (fill_r == DEPTH_C);
  assign new_slot  = fill_r[AW-1:0];
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign key = (item_r.op == arpc_pkg::OP_RX_REQ || item_r.op == arpc_pkg::OP_RX_REPLY) ?
               item_r.sender_ip : item_r.target_ip;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    fill_nxt      = fill_r;
    cmp_v_nxt     = cmp_v_r;
    cmp_idx_nxt   = cmp_idx_r;
    hit_nxt       = hit_r;
    row_nxt       = row_r;
    hit_ent_nxt   = hit_ent_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    wr_addr       = row_r;
    wr_entry.valid   = 1'b1;
    wr_entry.ip      = item_r.sender_ip;
    wr_entry.mac     = item_r.sender_mac;
    wr_entry.iface   = item_r.iface;
    wr_entry.hw_type = item_r.hw_type;
    wr_entry.waiter  = 8'd0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          idx_nxt   = '0;
          cmp_v_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmp_v_r && rd_match) begin
          hit_nxt     = 1'b1;
          row_nxt     = cmp_idx_r;
          hit_ent_nxt = rd_entry;
          cmp_v_nxt   = 1'b0;
          state_nxt   = S_ACT;
        end else if (issue) begin
          idx_nxt     = idx_r + 1'b1;
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = idx_r[AW-1:0];
        end else begin
          hit_nxt   = 1'b0;
          cmp_v_nxt = 1'b0;
          state_nxt = S_ACT;
        end
      end
      S_ACT: begin
        out_item_nxt  = '0;
        out_item_nxt.kind = arpc_pkg::KIND_NONE;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        case (item_r.op)
          arpc_pkg::OP_RX_REQ: begin
            if (item_r.target_ip == local_ip) begin
              if (!hit_r && full) begin
                out_item_nxt.kind = arpc_pkg::KIND_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = hit_r ? row_r : new_slot;
                if (!hit_r) begin
                  fill_nxt = fill_r + 1'b1;
                end
                out_item_nxt.kind        = arpc_pkg::KIND_REPLY;
                out_item_nxt.dest_mac    = item_r.sender_mac;
                out_item_nxt.dest_ip     = item_r.sender_ip;
                out_item_nxt.out_iface   = item_r.iface;
                out_item_nxt.out_hw_type = item_r.hw_type;
                out_item_nxt.out_hw_len  = item_r.hw_len;
              end
            end else if (hit_r) begin
              wr_en = 1'b1;
            end
          end
          arpc_pkg::OP_RX_REPLY: begin
            if (hit_r) begin
              wr_en = 1'b1;
              if (hit_ent_r.waiter != 8'd0) begin
                out_item_nxt.kind          = arpc_pkg::KIND_ANSWER;
                out_item_nxt.answer_client = hit_ent_r.waiter;
                out_item_nxt.answer_mac    = item_r.sender_mac;
              end
            end
          end
          arpc_pkg::OP_RESOLVE: begin
            if (hit_r) begin
              out_item_nxt.kind          = arpc_pkg::KIND_ANSWER;
              out_item_nxt.answer_client = item_r.client;
              out_item_nxt.answer_mac    = hit_ent_r.mac;
            end else if (full) begin
              out_item_nxt.kind = arpc_pkg::KIND_FULL;
            end else begin
              wr_en            = 1'b1;
              wr_addr          = new_slot;
              wr_entry.ip      = item_r.target_ip;
              wr_entry.mac     = '0;
              wr_entry.waiter  = item_r.client;
              fill_nxt         = fill_r + 1'b1;
              out_item_nxt.kind        = arpc_pkg::KIND_BCAST;
              out_item_nxt.dest_mac    = arpc_pkg::MAC_BCAST;
              out_item_nxt.dest_ip     = item_r.target_ip;
              out_item_nxt.out_iface   = item_r.iface;
              out_item_nxt.out_hw_type = item_r.hw_type;
              out_item_nxt.out_hw_len  = item_r.hw_len;
            end
          end
          arpc_pkg::OP_CLOSE: begin
            if (hit_r) begin
              wr_en          = 1'b1;
              wr_entry       = hit_ent_r;
              wr_entry.valid = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      fill_r      <= '0;
      cmp_v_r     <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      fill_r      <= fill_nxt;
      cmp_v_r     <= cmp_v_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    row_r      <= row_nxt;
    hit_ent_r  <= hit_ent_nxt;
    out_item_r <= out_item_nxt;
  end

`ifndef ASSERT_OFF
  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state not one-hot");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_C)
    else $error("fill count beyond depth");

  a_fill_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> fill_r >= $past(fill_r))
    else $error("fill count decreased");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_ACT))
    else $error("result strobe without action step");

  a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_SCAN))
    else $error("accepted transaction did not start a scan");
`endif

endmodule

// ----- design/arp_cache_responder.sv -----
// On start the controller walks the filled cache entries in order; it stops
// at the matching row on a hit, else after the last filled entry, and an
// action step then registers the result strobe. No new start is taken while
// busy; start is taken again in the strobe cycle. One entry compared per cycle.
// Reset (sync, rst_n low): cache empty, local_ip zero, no result pending.
// out_valid pulses one cycle; the receiver cannot stall.
module arp_cache_responder #(
  parameter int CACHE_DEPTH = arpc_pkg::CACHE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  arpc_pkg::in_item_t                in_item,
  output logic                              out_valid,
  output arpc_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(CACHE_DEPTH);

  logic [31:0]      local_ip_r;
  logic [31:0]      key;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             rd_match;
  logic             wr_en;
  arpc_pkg::entry_t rd_entry;
  arpc_pkg::entry_t wr_entry;

  // local_mac never reaches a result, so only local_ip is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0;
    end else if (cfg_we && cfg_index == arpc_pkg::REG_LOCAL_IP) begin
      local_ip_r <= cfg_wdata[31:0];
    end
  end

  arpc_table #(
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .key      (key),
    .rd_entry (rd_entry),
    .rd_match (rd_match)
  );

  arpc_ctrl #(
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .local_ip  (local_ip_r),
    .key       (key),
    .rd_addr   (rd_addr),
    .rd_match  (rd_match),
    .rd_entry  (rd_entry),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_entry  (wr_entry),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
